/* rtl/core/icfr_pkg.sv */
// ----------------------------------------------------------------------------
// icfr_pkg: shared definitions for the image chunk frame receiver
// Default sizes, operation, status and result codes, and the sequencer states.
// ----------------------------------------------------------------------------
package icfr_pkg;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int FRAME_BYTES   = 64;
  localparam int PAYLOAD_BYTES = 60;
  localparam int IMAGE_DEPTH   = 65536;

  // Frame layout.
  localparam logic [7:0] START_CODE    = 8'h43;
  localparam int         PAYLOAD_FIRST = 3;

  // Operations carried in the input tuser.
  localparam logic [1:0] OP_FRAME_BYTE = 2'd0;
  localparam logic [1:0] OP_READ       = 2'd1;
  localparam logic [1:0] OP_RESTART    = 2'd2;

  // Frame status codes.
  localparam logic [1:0] STATUS_OK           = 2'd0;
  localparam logic [1:0] STATUS_TOO_SHORT    = 2'd1;
  localparam logic [1:0] STATUS_BAD_START    = 2'd2;
  localparam logic [1:0] STATUS_BAD_CHECKSUM = 2'd3;

  // Result kinds carried in the output tuser.
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMMIT_RD,
    ST_COMMIT_WR,
    ST_READ_WAIT,
    ST_EMIT
  } state_t;

endpackage

/* rtl/core/icfr_ram.sv */
// ----------------------------------------------------------------------------
// icfr_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module icfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/image_chunk_frame_receiver.sv */
// ----------------------------------------------------------------------------
// image_chunk_frame_receiver: framed chunk receiver feeding an image store
// Checks byte-wide frames against an additive checksum and commits their
// payload into an image store; also serves image byte reads and restarts.
// ----------------------------------------------------------------------------
// A frame byte without the end mark and a restart leave the sequencer idle. A
// read passes the wait state for the registered read of the image store, then
// the emit state. A rejected frame's last byte goes to the emit state; for a
// valid frame the payload buffer and the image store are walked by one
// address adder and compare, a read and a write state per committed byte,
// until the payload ends or the image size is reached. The input is not ready
// while that commit runs. A result waits in the output register; the next item
// is taken meanwhile, but one with a result of its own then holds the emit state.
module image_chunk_frame_receiver #(
  parameter int FRAME_BYTES   = icfr_pkg::FRAME_BYTES,
  parameter int PAYLOAD_BYTES = icfr_pkg::PAYLOAD_BYTES,
  parameter int IMAGE_DEPTH   = icfr_pkg::IMAGE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: image_size.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // Input items.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [7:0] frame_byte, [23:8] read_address
  input  logic        s_tlast,   // frame_end
  input  logic [1:0]  s_tuser,   // operation
  // Result items.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [1:0] frame_status, [17:2] chunk_position,
                                 // [25:18] read_data, [26] image_ready, zeros
  output logic        m_tuser    // result_kind
);

  localparam int CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int IDX_W = $clog2(PAYLOAD_BYTES);
  localparam int AW    = $clog2(IMAGE_DEPTH);

  icfr_pkg::state_t state, state_next;

  logic [15:0]      image_size;
  logic [CNT_W-1:0] byte_count;
  logic [7:0]       running_sum;
  logic             start_ok;
  logic [7:0]       pos_high;
  logic [7:0]       pos_low;
  logic [15:0]      current_position;
  logic             ready_flag;
  logic [IDX_W-1:0] commit_idx;
  logic [16:0]      commit_addr;
  logic [1:0]       res_status;
  logic             res_kind;
  logic [7:0]       res_data;
  logic             read_in_range;

  logic             acc;
  logic [7:0]       in_byte;
  logic [15:0]      in_raddr;
  logic             below_frame;
  logic [CNT_W-1:0] count_new;
  logic [8:0]       idx_wide;
  logic [8:0]       pl_off;
  logic             pl_we;
  logic [7:0]       pl_rdata;
  logic [16:0]      commit_addr_next;
  logic             commit_stop;
  logic             commit_last;
  logic             img_we;
  logic [7:0]       img_rdata;
  logic [1:0]       frame_status;
  logic             out_load;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == icfr_pkg::ST_IDLE);
  assign acc       = s_tvalid && s_tready;
  assign in_byte   = s_tdata[7:0];
  assign in_raddr  = s_tdata[23:8];

  // Byte position bookkeeping for the incoming frame byte.
  assign below_frame = byte_count < CNT_W'(FRAME_BYTES);
  assign count_new   = below_frame ? byte_count + CNT_W'(1) : byte_count;
  assign idx_wide    = 9'(byte_count);
  assign pl_off      = idx_wide - 9'(icfr_pkg::PAYLOAD_FIRST);
  assign pl_we       = acc && (s_tuser == icfr_pkg::OP_FRAME_BYTE) && below_frame &&
                       (idx_wide >= 9'(icfr_pkg::PAYLOAD_FIRST)) &&
                       (idx_wide < 9'(icfr_pkg::PAYLOAD_FIRST + PAYLOAD_BYTES));

  // Frame verdict at the last byte, in order of precedence.
  always_comb begin
    if (count_new < CNT_W'(FRAME_BYTES)) begin
      frame_status = icfr_pkg::STATUS_TOO_SHORT;
    end else if (!start_ok) begin
      frame_status = icfr_pkg::STATUS_BAD_START;
    end else if (running_sum != in_byte) begin
      frame_status = icfr_pkg::STATUS_BAD_CHECKSUM;
    end else begin
      frame_status = icfr_pkg::STATUS_OK;
    end
  end

  // Shared commit unit: image address and its compare against the image size.
  assign commit_addr_next = {1'b0, current_position} + 17'(commit_idx);
  assign commit_stop      = commit_addr_next >= {1'b0, image_size};
  assign commit_last      = commit_idx == IDX_W'(PAYLOAD_BYTES - 1);
  assign img_we           = (state == icfr_pkg::ST_COMMIT_WR) &&
                            (commit_addr < 17'(IMAGE_DEPTH));

  assign out_load = (state == icfr_pkg::ST_EMIT) && (!m_tvalid || m_tready);

  // Payload buffer for the current frame.
  icfr_ram #(
    .WIDTH(8),
    .DEPTH(PAYLOAD_BYTES)
  ) u_payload (
    .clk  (clk),
    .we   (pl_we),
    .waddr(pl_off[IDX_W-1:0]),
    .wdata(in_byte),
    .raddr(commit_idx),
    .rdata(pl_rdata)
  );

  // Image store.
  icfr_ram #(
    .WIDTH(8),
    .DEPTH(IMAGE_DEPTH)
  ) u_image (
    .clk  (clk),
    .we   (img_we),
    .waddr(commit_addr[AW-1:0]),
    .wdata(pl_rdata),
    .raddr(in_raddr[AW-1:0]),
    .rdata(img_rdata)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= icfr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      icfr_pkg::ST_IDLE: begin
        if (acc && (s_tuser == icfr_pkg::OP_FRAME_BYTE) && s_tlast) begin
          if (frame_status == icfr_pkg::STATUS_OK) begin
            state_next = icfr_pkg::ST_COMMIT_RD;
          end else begin
            state_next = icfr_pkg::ST_EMIT;
          end
        end else if (acc && (s_tuser == icfr_pkg::OP_READ)) begin
          state_next = icfr_pkg::ST_READ_WAIT;
        end
      end
      icfr_pkg::ST_COMMIT_RD: begin
        if (commit_stop) begin
          state_next = icfr_pkg::ST_EMIT;
        end else begin
          state_next = icfr_pkg::ST_COMMIT_WR;
        end
      end
      icfr_pkg::ST_COMMIT_WR: begin
        if (commit_last) begin
          state_next = icfr_pkg::ST_EMIT;
        end else begin
          state_next = icfr_pkg::ST_COMMIT_RD;
        end
      end
      icfr_pkg::ST_READ_WAIT: begin
        state_next = icfr_pkg::ST_EMIT;
      end
      icfr_pkg::ST_EMIT: begin
        if (out_load) begin
          state_next = icfr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = icfr_pkg::ST_IDLE;
      end
    endcase
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      image_size <= cfg_data;
    end
  end

  // Frame assembly state.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_sum <= 8'd0;
      start_ok    <= 1'b0;
      pos_high    <= 8'd0;
      pos_low     <= 8'd0;
    end else if (acc && (s_tuser == icfr_pkg::OP_FRAME_BYTE)) begin
      if (s_tlast) begin
        byte_count  <= '0;
        running_sum <= 8'd0;
        start_ok    <= 1'b0;
        pos_high    <= 8'd0;
        pos_low     <= 8'd0;
      end else begin
        byte_count  <= count_new;
        running_sum <= running_sum + in_byte;
        if (below_frame && (byte_count == CNT_W'(0))) begin
          start_ok <= (in_byte == icfr_pkg::START_CODE);
        end
        if (below_frame && (byte_count == CNT_W'(1))) begin
          pos_high <= in_byte;
        end
        if (below_frame && (byte_count == CNT_W'(2))) begin
          pos_low <= in_byte;
        end
      end
    end
  end

  // Image position and ready flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_position <= 16'd0;
      ready_flag       <= 1'b0;
    end else if (acc && (s_tuser == icfr_pkg::OP_RESTART)) begin
      current_position <= 16'd0;
      ready_flag       <= 1'b0;
    end else if (acc && (s_tuser == icfr_pkg::OP_FRAME_BYTE) && s_tlast &&
                 (frame_status == icfr_pkg::STATUS_OK)) begin
      current_position <= {pos_high, pos_low};
    end else if ((state == icfr_pkg::ST_COMMIT_RD) && commit_stop) begin
      ready_flag <= 1'b1;
    end
  end

  // Commit walk over the payload buffer.
  always_ff @(posedge clk) begin
    if (state == icfr_pkg::ST_IDLE) begin
      commit_idx <= '0;
    end else if (state == icfr_pkg::ST_COMMIT_RD) begin
      commit_addr <= commit_addr_next;
    end else if ((state == icfr_pkg::ST_COMMIT_WR) && !commit_last) begin
      commit_idx <= commit_idx + IDX_W'(1);
    end
  end

  // Pending result fields.
  always_ff @(posedge clk) begin
    if (acc && (s_tuser == icfr_pkg::OP_FRAME_BYTE) && s_tlast) begin
      res_kind   <= icfr_pkg::KIND_FRAME;
      res_status <= frame_status;
      res_data   <= 8'd0;
    end else if (acc && (s_tuser == icfr_pkg::OP_READ)) begin
      res_kind      <= icfr_pkg::KIND_READ;
      res_status    <= icfr_pkg::STATUS_OK;
      read_in_range <= {1'b0, in_raddr} < 17'(IMAGE_DEPTH);
    end else if (state == icfr_pkg::ST_READ_WAIT) begin
      res_data <= read_in_range ? img_rdata : 8'd0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= res_kind;
      m_tdata <= {5'd0, ready_flag, res_data, current_position, res_status};
    end
  end

`ifndef ASSERT_OFF
  // The image store is written only inside the image size and the store depth.
  a_img_write_range: assert property (@(posedge clk) disable iff (rst)
    img_we |-> (commit_addr < {1'b0, image_size}) && (commit_addr < 17'(IMAGE_DEPTH)))
    else $error("image store written outside the image");

  // The ready flag drops only on a restart.
  a_ready_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(ready_flag) && !$past(rst) |->
      $past(acc && (s_tuser == icfr_pkg::OP_RESTART)))
    else $error("ready flag cleared without a restart");

  // A commit always follows a frame that passed every check.
  a_commit_ok: assert property (@(posedge clk) disable iff (rst)
    (state == icfr_pkg::ST_COMMIT_RD) |-> (res_status == icfr_pkg::STATUS_OK) &&
      (res_kind == icfr_pkg::KIND_FRAME))
    else $error("commit started for a rejected frame");

  // A read result carries the ok status.
  a_read_status: assert property (@(posedge clk) disable iff (rst)
    out_load && (res_kind == icfr_pkg::KIND_READ) |=>
      (m_tdata[1:0] == icfr_pkg::STATUS_OK))
    else $error("read result with a frame status");
`endif

endmodule
